[hdl/slrd_pkg.sv]
package slrd_pkg;

  // Write position and image size width
  localparam int unsigned PosW = 24;
  // Repeat count width: a negative 16-bit length gives 1 .. 32768
  localparam int unsigned CntW = 16;
  localparam int unsigned LitW = 15;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW = $clog2(QueueDepth);
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);

  localparam logic [7:0] FillByte = 8'hF6;

  // Input flag codes
  localparam logic OpByte = 1'b0;
  localparam logic OpEof  = 1'b1;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_RUN     = 2'd0,
    KIND_FILL    = 2'd1,
    KIND_CORRUPT = 2'd2
  } kind_e;

  // Parse phase of the front end
  typedef enum logic [1:0] {
    PH_LEN_LO  = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_REPEAT  = 2'd2,
    PH_LITERAL = 2'd3
  } phase_e;

  // Action handed from front to back
  typedef enum logic [1:0] {
    ACT_RUN     = 2'd0,
    ACT_FILL    = 2'd1,
    ACT_CORRUPT = 2'd2
  } act_e;

  typedef struct packed {
    act_e              act;
    logic [7:0]        value;
    logic [CntW-1:0]   count;
  } action_t;

  // Status the back end reports to the front end
  typedef struct packed {
    logic done;
  } back_status_t;

endpackage

[hdl/slrd_front.sv]
module slrd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_eof_i,
  input  logic [7:0]            in_byte_i,
  output logic                  in_ready_o,
  input  slrd_pkg::back_status_t status_i,
  output logic                  push_o,
  output slrd_pkg::action_t     push_data_o,
  input  logic                  q_full_i
);
  import slrd_pkg::*;

  phase_e            phase_q, phase_d;
  logic [7:0]        len_lo_q, len_lo_d;
  logic [CntW-1:0]   rep_cnt_q, rep_cnt_d;
  logic [LitW-1:0]   lit_left_q, lit_left_d;
  logic              err_q, err_d;
  logic              take;
  logic [15:0]       raw_len;

  assign in_ready_o = !q_full_i;
  // Words arriving after an error or a finished image are dropped untouched
  assign take       = in_valid_i && !q_full_i && !err_q && !status_i.done;
  assign raw_len    = {in_byte_i, len_lo_q};

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (take) begin
      if (in_eof_i == OpEof) begin
        phase_d = PH_LEN_LO;
      end else begin
        unique case (phase_q)
          PH_LEN_LO: phase_d = PH_LEN_HI;
          PH_LEN_HI: begin
            if (raw_len[15]) begin
              phase_d = PH_REPEAT;
            end else if (raw_len != 16'd0) begin
              phase_d = PH_LITERAL;
            end else begin
              phase_d = PH_LEN_LO;
            end
          end
          PH_REPEAT: phase_d = PH_LEN_LO;
          PH_LITERAL: begin
            if (lit_left_q == LitW'(1)) phase_d = PH_LEN_LO;
          end
          default: phase_d = PH_LEN_LO;
        endcase
      end
    end
  end

  // Datapath registers and queue actions
  always_comb begin
    len_lo_d    = len_lo_q;
    rep_cnt_d   = rep_cnt_q;
    lit_left_d  = lit_left_q;
    err_d       = err_q;
    push_o      = 1'b0;
    push_data_o = '{act: ACT_RUN, value: in_byte_i, count: CntW'(1)};
    if (take) begin
      if (in_eof_i == OpEof) begin
        push_o = 1'b1;
        if (phase_q == PH_LEN_LO || phase_q == PH_LEN_HI) begin
          push_data_o.act = ACT_FILL;
        end else begin
          push_data_o.act = ACT_CORRUPT;
          err_d           = 1'b1;
        end
      end else begin
        unique case (phase_q)
          PH_LEN_LO: len_lo_d = in_byte_i;
          PH_LEN_HI: begin
            // Negate the length: 0x8000 maps to a count of 32768
            if (raw_len[15]) rep_cnt_d = CntW'(16'd0 - raw_len);
            else             lit_left_d = raw_len[LitW-1:0];
          end
          PH_REPEAT: begin
            push_o            = 1'b1;
            push_data_o.count = rep_cnt_q;
          end
          PH_LITERAL: begin
            push_o     = 1'b1;
            lit_left_d = lit_left_q - LitW'(1);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEN_LO;
      err_q      <= 1'b0;
      len_lo_q   <= '0;
      rep_cnt_q  <= '0;
      lit_left_q <= '0;
    end else begin
      phase_q    <= phase_d;
      err_q      <= err_d;
      len_lo_q   <= len_lo_d;
      rep_cnt_q  <= rep_cnt_d;
      lit_left_q <= lit_left_d;
    end
  end

endmodule

[hdl/slrd_queue.sv]
module slrd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  slrd_pkg::action_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output slrd_pkg::action_t pop_data_o
);
  import slrd_pkg::*;

  action_t            mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == QCntW'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Store incoming actions
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[hdl/slrd_back.sv]
module slrd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [slrd_pkg::PosW-1:0] image_size_i,
  input  logic                   q_empty_i,
  input  slrd_pkg::action_t      q_data_i,
  output logic                   q_pop_o,
  output slrd_pkg::back_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output slrd_pkg::kind_e        out_kind_o,
  output logic [7:0]             out_value_o,
  output logic [slrd_pkg::PosW-1:0] out_count_o,
  output logic                   out_complete_o
);
  import slrd_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic            fin_q, fin_d;
  logic            err_q, err_d;
  logic            done;
  logic [PosW-1:0] room;
  logic [PosW-1:0] req;
  logic            fits_all;
  logic [PosW-1:0] n;
  logic            emit;

  logic            ov_q, ov_d;
  kind_e           kind_q, kind_d;
  logic [7:0]      value_q, value_d;
  logic [PosW-1:0] count_q, count_d;
  logic            cmpl_q, cmpl_d;

  assign done            = fin_q || (pos_q >= image_size_i);
  assign status_o.done   = done;
  assign q_pop_o         = !q_empty_i && (!ov_q || out_ready_i);
  assign room            = image_size_i - pos_q;
  assign req             = (q_data_i.act == ACT_FILL) ? room : PosW'(q_data_i.count);
  // A run that reaches the image end is trimmed to the space left
  assign fits_all        = (req >= room);
  assign n               = fits_all ? room : req;
  assign emit            = q_pop_o && !done && !err_q;

  // Carry out one action
  always_comb begin
    pos_d   = pos_q;
    fin_d   = fin_q;
    err_d   = err_q;
    ov_d    = ov_q && !out_ready_i;
    kind_d  = kind_q;
    value_d = value_q;
    count_d = count_q;
    cmpl_d  = cmpl_q;
    if (emit) begin
      ov_d = 1'b1;
      unique case (q_data_i.act)
        ACT_CORRUPT: begin
          err_d   = 1'b1;
          kind_d  = KIND_CORRUPT;
          value_d = 8'd0;
          count_d = '0;
          cmpl_d  = 1'b0;
        end
        ACT_FILL, ACT_RUN: begin
          pos_d   = pos_q + n;
          fin_d   = fits_all;
          kind_d  = (q_data_i.act == ACT_FILL) ? KIND_FILL : KIND_RUN;
          value_d = (q_data_i.act == ACT_FILL) ? FillByte : q_data_i.value;
          count_d = n;
          cmpl_d  = fits_all;
        end
        default: ov_d = ov_q && !out_ready_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      fin_q <= 1'b0;
      err_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      fin_q <= fin_d;
      err_q <= err_d;
      ov_q  <= ov_d;
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    count_q <= count_d;
    cmpl_q  <= cmpl_d;
  end

  assign out_valid_o    = ov_q;
  assign out_kind_o     = kind_q;
  assign out_value_o    = value_q;
  assign out_count_o    = count_q;
  assign out_complete_o = cmpl_q;

  a_corrupt_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && kind_q == KIND_CORRUPT) |-> (count_q == '0 && !cmpl_q && err_q))
    else $error("corrupt word carries a run");

  a_finish_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fin_q) |-> (ov_q && cmpl_q))
    else $error("image finished without a completing word");

  a_complete_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && cmpl_q) |-> fin_q)
    else $error("completing word without finished image");

  a_no_work_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(err_q) |-> !emit)
    else $error("action carried out after an error");

endmodule

[hdl/signed_length_rle_decoder_top.sv]
// Signed-length run-length decoder. Each input word is one compressed byte
// (tuser = 0) or an end-of-file mark (tuser = 1). Blocks open with a 16-bit
// little-endian signed length: negative repeats the next byte, positive
// passes literal bytes, zero is skipped. Each output word is a run
// descriptor (value, count) with its kind in tuser: 0 decoded run, 1 end-of-
// file fill of 0xF6 up to the image size, 2 corrupt stream. Runs are trimmed
// to the configured image size; after the image is complete or a corrupt word
// was sent, input words are taken and dropped until reset. One input word is
// taken per cycle while the queue has room: a front parser feeds a two-entry
// action queue that a back unit drains into an output register at one action
// per cycle unless stalled, in a single step (compare, trim, position add).
module signed_length_rle_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [23:0] cfg_wr_data_i,   // image_size_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tuser,    // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,    // [7:0] run_value, [31:8] run_count,
                                       // [32] image_complete, rest zero
  output logic [1:0]  m_axis_tuser     // [1:0] result_kind
);
  import slrd_pkg::*;

  logic [PosW-1:0] size_q;
  back_status_t    status;
  logic            push, full, pop, empty;
  action_t         push_data, pop_data;
  kind_e           kind;
  logic [7:0]      value;
  logic [PosW-1:0] count;
  logic            cmpl;

  // Hold the image size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (cfg_wr_en_i) begin
      size_q <= PosW'(cfg_wr_data_i);
    end
  end

  slrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_eof_i    (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (full)
  );

  slrd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  slrd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_size_i   (size_q),
    .q_empty_i      (empty),
    .q_data_i       (pop_data),
    .q_pop_o        (pop),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_kind_o     (kind),
    .out_value_o    (value),
    .out_count_o    (count),
    .out_complete_o (cmpl)
  );

  // Pack the result word
  assign m_axis_tdata = {7'd0, cmpl, 24'(count), value};
  assign m_axis_tuser = kind;

endmodule
